@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ sv/yawsi_pkg.sv @@
// Shared widths, constants and types of the yaw stillness integrator.
// No dependencies.
package yawsi_pkg;

	localparam int FRAC_W     = 22;
	localparam int DEPTH      = 128;
	localparam int YAW_W      = 31;
	localparam int DELTA_W    = 32;
	localparam int DX_W       = DELTA_W + 1;
	localparam int LEN_W      = 8;
	localparam int THR_W      = 31;
	localparam int FILL_W     = 8;
	localparam int HEAD_W     = 48;
	localparam int HEAD_X_W   = HEAD_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = DELTA_W + $clog2(DEPTH);
	localparam int PROD_W     = THR_W + CNT_W;
	localparam int CMP_W      = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int LEN_CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(419);

	localparam logic signed [DX_W-1:0] HALF_TURN = DX_W'(180 * (longint'(1) << FRAC_W));
	localparam logic signed [DX_W-1:0] FULL_TURN = DX_W'(360 * (longint'(1) << FRAC_W));
	localparam logic signed [HEAD_X_W-1:0] HEAD_MAX =
		HEAD_X_W'((longint'(1) << (HEAD_W - 1)) - 1);

	typedef logic signed [YAW_W-1:0]   yaw_t;
	typedef logic signed [DELTA_W-1:0] delta_t;

	// per-cycle control broadcast to every window cell
	typedef struct packed {
		logic adv;   // an item enters the window
		logic grow;  // window grows, tail marker moves one cell on
	} cell_ctrl_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH   = 2'd0,
		REG_STILL_THRESHOLD = 2'd1
	} reg_idx_t;

endpackage

@@ sv/yawsi_cell.sv @@
// One window cell: a stored delta and the tail marker of the window.
// Depends on yawsi_pkg.
module yawsi_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  yawsi_pkg::cell_ctrl_t ctrl,
	input  yawsi_pkg::delta_t     din,
	input  logic                  tail_in,
	output yawsi_pkg::delta_t     dout,
	output logic                  tail_out
);

	yawsi_pkg::delta_t val_q;
	logic              tail_q;

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			val_q <= din;
		end
	end

	// marker stays put while the window slides at constant length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else if (ctrl.adv && ctrl.grow) begin
			tail_q <= tail_in;
		end
	end

	assign dout     = val_q;
	assign tail_out = tail_q;

endmodule

@@ sv/yawsi_window.sv @@
// Sliding delta window: row of cells, running sum, fill count.
// Depends on yawsi_pkg, yawsi_cell and assert_macros.svh.
`include "assert_macros.svh"

module yawsi_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  yawsi_pkg::delta_t                   delta_in,
	input  logic [yawsi_pkg::LEN_W-1:0]         len,
	output logic signed [yawsi_pkg::SUM_W-1:0]  sum,
	output logic [yawsi_pkg::CNT_W-1:0]         count
);

	logic [yawsi_pkg::CNT_W-1:0]        count_q;
	logic [yawsi_pkg::CNT_W-1:0]        len_eff;
	logic [yawsi_pkg::LEN_CMP_W-1:0]    len_x;
	logic signed [yawsi_pkg::SUM_W-1:0] sum_q;
	yawsi_pkg::delta_t                  leave_q;
	yawsi_pkg::delta_t                  leave_next;
	yawsi_pkg::delta_t                  picked;
	logic                               grow;
	yawsi_pkg::cell_ctrl_t              ctrl;

	// chain[0] is the incoming delta, chain[k+1] the content of cell k
	yawsi_pkg::delta_t                  chain [yawsi_pkg::DEPTH+1];
	// tail_chain[k+1] marks cell k as the oldest entry
	logic [yawsi_pkg::DEPTH+1:0]        tail_chain;

	always_comb begin
		len_x = yawsi_pkg::LEN_CMP_W'(len);
		priority if (len == '0) begin
			len_eff = yawsi_pkg::CNT_W'(1);
		end else if (len_x > yawsi_pkg::LEN_CMP_W'(yawsi_pkg::DEPTH)) begin
			len_eff = yawsi_pkg::CNT_W'(yawsi_pkg::DEPTH);
		end else begin
			len_eff = yawsi_pkg::CNT_W'(len_x);
		end
	end

	assign grow      = count_q < len_eff;
	assign ctrl.adv  = load;
	assign ctrl.grow = grow;

	assign chain[0]                        = delta_in;
	assign tail_chain[0]                   = (count_q == '0);
	assign tail_chain[yawsi_pkg::DEPTH+1]  = 1'b0;

	for (genvar k = 0; k < yawsi_pkg::DEPTH; k++) begin : g_cell
		yawsi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.din      (chain[k]),
			.tail_in  (tail_chain[k]),
			.dout     (chain[k+1]),
			.tail_out (tail_chain[k+1])
		);
	end

	// next-oldest entry: the cell just ahead of the tail marker
	always_comb begin
		picked = '0;
		for (int k = 0; k < yawsi_pkg::DEPTH; k++) begin
			if (tail_chain[k+2]) begin
				picked = picked | chain[k+1];
			end
		end
	end

	always_comb begin
		if (grow) begin
			leave_next = (count_q == '0) ? delta_in : leave_q;
		end else begin
			leave_next = (count_q == yawsi_pkg::CNT_W'(1)) ? delta_in : picked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (load) begin
			if (grow) begin
				sum_q   <= sum_q + yawsi_pkg::SUM_W'(delta_in);
				count_q <= count_q + yawsi_pkg::CNT_W'(1);
			end else begin
				sum_q   <= sum_q + yawsi_pkg::SUM_W'(delta_in) - yawsi_pkg::SUM_W'(leave_q);
			end
		end
	end

	// oldest delta, fetched one item ahead
	always_ff @(posedge clk) begin
		if (load) begin
			leave_q <= leave_next;
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

	`ASSERT_IMPLIES(a_tail_onehot, count_q != '0, $onehot(tail_chain[yawsi_pkg::DEPTH:1]), "tail marker not one-hot")
	`ASSERT_NEXT(a_grow_step, load && grow, count_q == $past(count_q) + yawsi_pkg::CNT_W'(1), "count did not grow by one")
	`ASSERT_NEXT(a_slide_hold, load && !grow, $stable(count_q), "count moved while sliding")

endmodule

@@ sv/yaw_stillness_integrator.sv @@
// Top level of the yaw stillness integrator: delta, window, still test, heading.
// Depends on yawsi_pkg and yawsi_window.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid / in_stall       | yaw_sample
//  out     | out_valid / out_stall     | yaw_delta, is_still, heading, fill_count
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low; five register stages,
// s1 to s5, run from sample capture to the result at the output.
// The rate is set by the window stage: every cell shifts at once and the
// oldest delta is fetched one item ahead, so the running sum is one add/sub.
// Reset clears previous yaw, window sum, fill count, heading and loads the
// register defaults (length 100, threshold 419); window cell deltas hold no reset.
// Stages collapse bubbles; a stalled result is held in the output stage while
// upstream stages keep taking items until they fill.
module yaw_stillness_integrator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  yawsi_pkg::yaw_t                     yaw_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output yawsi_pkg::delta_t                   yaw_delta,
	output logic                                is_still,
	output logic signed [yawsi_pkg::HEAD_W-1:0] heading,
	output logic [yawsi_pkg::FILL_W-1:0]        fill_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [yawsi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [yawsi_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// config registers
	logic [yawsi_pkg::LEN_W-1:0] len_q;
	logic [yawsi_pkg::THR_W-1:0] thr_q;

	// stage valids and moves
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// s1: captured sample and its predecessor
	yawsi_pkg::yaw_t   prev_q;
	yawsi_pkg::yaw_t   cur_s1, prev_s1;
	// s2: seam-corrected delta
	yawsi_pkg::delta_t delta_s2;
	// s3: window state lives in the window block
	yawsi_pkg::delta_t delta_s3;
	// s4: magnitude of the sum and threshold times count
	yawsi_pkg::delta_t                  delta_s4;
	logic [yawsi_pkg::SUM_W-1:0]        abs_s4;
	logic [yawsi_pkg::PROD_W-1:0]       prod_s4;
	logic [yawsi_pkg::CNT_W-1:0]        cnt_s4;
	// s5: result
	yawsi_pkg::delta_t                  delta_s5;
	logic                               still_s5;
	logic [yawsi_pkg::FILL_W-1:0]       fill_s5;
	logic signed [yawsi_pkg::HEAD_W-1:0] heading_q;

	// delta datapath
	logic signed [yawsi_pkg::DX_W-1:0] cur_x, prev_x, diff, mag_c, mag_p, adj, sat;
	logic                              wide;
	yawsi_pkg::delta_t                 delta_d;

	// window outputs
	logic signed [yawsi_pkg::SUM_W-1:0] win_sum;
	logic [yawsi_pkg::CNT_W-1:0]        win_cnt;
	logic [yawsi_pkg::SUM_W-1:0]        abs_d;
	logic [yawsi_pkg::PROD_W-1:0]       prod_d;

	// still test and heading
	logic                                   still_d;
	logic signed [yawsi_pkg::HEAD_X_W-1:0]  head_sum, head_sat;

	// ---------------- config port ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= yawsi_pkg::LEN_RESET;
			thr_q <= yawsi_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == yawsi_pkg::REG_WINDOW_LENGTH) begin
				len_q <= cfg_data[yawsi_pkg::LEN_W-1:0];
			end else if (cfg_index == yawsi_pkg::REG_STILL_THRESHOLD) begin
				thr_q <= cfg_data[yawsi_pkg::THR_W-1:0];
			end
		end
	end

	// ---------------- flow control ----------------
	// a stage moves when empty or when the next one moves
	assign rdy5 = !vld_s5 || !out_stall;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- s1: sample capture ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (in_valid && rdy1) begin
			prev_q <= yaw_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			cur_s1  <= yaw_sample;
			prev_s1 <= prev_q;
		end
	end

	// ---------------- s2: seam-corrected delta ----------------
	always_comb begin
		cur_x  = yawsi_pkg::DX_W'(cur_s1);
		prev_x = yawsi_pkg::DX_W'(prev_s1);
		diff   = cur_x - prev_x;
		mag_c  = cur_s1[yawsi_pkg::YAW_W-1] ? -cur_x : cur_x;
		mag_p  = prev_s1[yawsi_pkg::YAW_W-1] ? -prev_x : prev_x;
		wide   = (mag_c + mag_p) > yawsi_pkg::HALF_TURN;
		// crossing the +/-180 seam: take the short way round
		priority if (wide && prev_s1 < 0 && cur_s1 > 0) begin
			adj = diff - yawsi_pkg::FULL_TURN;
		end else if (wide && prev_s1 > 0 && cur_s1 < 0) begin
			adj = diff + yawsi_pkg::FULL_TURN;
		end else begin
			adj = diff;
		end
		// out-of-range samples: clamp to one full turn
		priority if (adj > yawsi_pkg::FULL_TURN) begin
			sat = yawsi_pkg::FULL_TURN;
		end else if (adj < -yawsi_pkg::FULL_TURN) begin
			sat = -yawsi_pkg::FULL_TURN;
		end else begin
			sat = adj;
		end
		delta_d = yawsi_pkg::DELTA_W'(sat);
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy2) begin
			delta_s2 <= delta_d;
		end
	end

	// ---------------- s3: window update ----------------
	yawsi_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (vld_s2 && rdy3),
		.delta_in (delta_s2),
		.len      (len_q),
		.sum      (win_sum),
		.count    (win_cnt)
	);

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy3) begin
			delta_s3 <= delta_s2;
		end
	end

	// ---------------- s4: |sum| and threshold * count ----------------
	// |mean| < thr rewritten as |sum| < thr * count
	assign abs_d  = win_sum[yawsi_pkg::SUM_W-1] ? yawsi_pkg::SUM_W'(-win_sum)
	                                            : yawsi_pkg::SUM_W'(win_sum);
	assign prod_d = yawsi_pkg::PROD_W'(thr_q) * yawsi_pkg::PROD_W'(win_cnt);

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy4) begin
			delta_s4 <= delta_s3;
			abs_s4   <= abs_d;
			prod_s4  <= prod_d;
			cnt_s4   <= win_cnt;
		end
	end

	// ---------------- s5: still test, heading ----------------
	assign still_d  = yawsi_pkg::CMP_W'(abs_s4) < yawsi_pkg::CMP_W'(prod_s4);
	assign head_sum = yawsi_pkg::HEAD_X_W'(heading_q) + yawsi_pkg::HEAD_X_W'(delta_s4);

	always_comb begin
		priority if (head_sum > yawsi_pkg::HEAD_MAX) begin
			head_sat = yawsi_pkg::HEAD_MAX;
		end else if (head_sum < -yawsi_pkg::HEAD_MAX) begin
			head_sat = -yawsi_pkg::HEAD_MAX;
		end else begin
			head_sat = head_sum;
		end
	end

	// heading only integrates while moving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
		end else if (vld_s4 && rdy5 && !still_d) begin
			heading_q <= yawsi_pkg::HEAD_W'(head_sat);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && rdy5) begin
			delta_s5 <= delta_s4;
			still_s5 <= still_d;
			fill_s5  <= yawsi_pkg::FILL_W'(cnt_s4);
		end
	end

	assign out_valid  = vld_s5;
	assign yaw_delta  = delta_s5;
	assign is_still   = still_s5;
	assign heading    = heading_q;
	assign fill_count = fill_s5;

endmodule
